// ----- hdl/isort_pkg.sv -----
package isort_pkg;

  localparam int unsigned ITEM_W       = 32;
  localparam int unsigned SHIFT_W      = 11;
  localparam int unsigned MAX_ITEMS_DEF = 64;
  localparam logic [SHIFT_W-1:0] SHIFT_SAT = '1;

  typedef struct packed {
    logic insert;
    logic drain;
  } cell_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SETTLE = 3'b010,
    ST_DRAIN  = 3'b100
  } state_e;

endpackage

// ----- hdl/isort_in_if.sv -----
interface isort_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [isort_pkg::ITEM_W-1:0] item_value;
  logic                                last_item;

  modport source (output valid, output item_value, output last_item, input ready);
  modport sink   (input valid, input item_value, input last_item, output ready);
endinterface

// ----- hdl/isort_out_if.sv -----
interface isort_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [isort_pkg::ITEM_W-1:0]  sorted_value;
  logic                                 last_out;
  logic        [isort_pkg::SHIFT_W-1:0] shift_count;
  logic                                 overflow;

  modport source (output valid, output sorted_value, output last_out,
                  output shift_count, output overflow, input ready);
  modport sink   (input valid, input sorted_value, input last_out,
                  input shift_count, input overflow, output ready);
endinterface

// ----- hdl/isort_cell.sv -----
module isort_cell (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  isort_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [isort_pkg::ITEM_W-1:0] item_i,
  input  logic signed [isort_pkg::ITEM_W-1:0] left_value_i,
  input  logic                                left_valid_i,
  input  logic                                left_gt_i,
  input  logic signed [isort_pkg::ITEM_W-1:0] right_value_i,
  input  logic                                right_valid_i,
  output logic signed [isort_pkg::ITEM_W-1:0] value_o,
  output logic                                valid_o,
  output logic                                gt_o
);

  logic signed [isort_pkg::ITEM_W-1:0] value_q, value_d;
  logic                                valid_q, valid_d;

  // strictly greater only, so equal items stay ahead of the newcomer
  assign gt_o = valid_q && (value_q > item_i);

  always_comb begin
    value_d = value_q;
    valid_d = valid_q;
    priority if (ctrl_i.drain) begin
      value_d = right_value_i;
      valid_d = right_valid_i;
    end else if (ctrl_i.insert) begin
      if (gt_o || !valid_q) begin
        value_d = left_gt_i ? left_value_i : item_i;
      end
      valid_d = valid_q | left_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign valid_o = valid_q;

endmodule

// ----- hdl/insertion_sorter_with_shift_count.sv -----
// Channel  Dir  Beat payload                                    Handshake
// in_i     in   item_value[31:0] signed, last_item              valid/ready
// out_o    out  sorted_value[31:0] signed, last_out,            valid/ready
//               shift_count[10:0], overflow
//
// One item is taken per cycle while collecting; each cell of the chain compares
// against the broadcast item and shifts right in that same cycle.
// After a last item, with no input meanwhile, the SETTLE state forms the shift
// total; then the set leaves cell 0 one beat per ready cycle as the chain shifts left.
// Output stalls hold the chain. Reset empties the chain and clears all counts.
module insertion_sorter_with_shift_count #(
  parameter int unsigned MAX_ITEMS = isort_pkg::MAX_ITEMS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  isort_in_if.sink   in_i,
  isort_out_if.source out_o
);

  localparam int unsigned OCC_W = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SUM_W = isort_pkg::SHIFT_W + 1;

  isort_pkg::state_e state_q, state_d;

  logic [OCC_W-1:0]                occ_q, occ_d;
  logic [OCC_W-1:0]                snap_q;
  logic [MAX_ITEMS-1:0]            gt_q;
  logic                            acc_q, acc_d;
  logic [isort_pkg::SHIFT_W-1:0]   total_q, total_d;
  logic                            dropped_q, dropped_d;

  logic signed [isort_pkg::ITEM_W-1:0] cell_value [MAX_ITEMS];
  logic [MAX_ITEMS-1:0]            cell_valid;
  logic [MAX_ITEMS-1:0]            cell_gt;
  isort_pkg::cell_ctrl_t           ctrl;

  logic in_beat, out_beat, has_room, last_beat;
  logic [OCC_W-1:0] pos;
  logic [OCC_W-1:0] moved;
  logic [SUM_W-1:0] sum;

  assign in_i.ready = (state_q == isort_pkg::ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign has_room   = (occ_q < OCC_W'(MAX_ITEMS));

  assign out_o.valid        = (state_q == isort_pkg::ST_DRAIN);
  assign out_o.sorted_value = cell_value[0];
  assign out_o.last_out     = !cell_valid[1];
  assign out_o.shift_count  = total_q;
  assign out_o.overflow     = dropped_q;
  assign out_beat  = out_o.valid && out_o.ready;
  assign last_beat = out_beat && out_o.last_out;

  assign ctrl.insert = in_beat && has_room;
  assign ctrl.drain  = out_beat;

  // the greater flags form a run ending at the top occupied cell
  always_comb begin
    pos = snap_q;
    for (int i = MAX_ITEMS - 1; i >= 0; i--) begin
      if (gt_q[i]) begin
        pos = OCC_W'(i);
      end
    end
  end

  assign moved = snap_q - pos;
  assign sum   = {1'b0, total_q} + SUM_W'(moved);

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    logic signed [isort_pkg::ITEM_W-1:0] left_value, right_value;
    logic left_valid, left_gt, right_valid;

    if (g == 0) begin : g_first
      assign left_value = in_i.item_value;
      assign left_valid = 1'b1;
      assign left_gt    = 1'b0;
    end else begin : g_mid
      assign left_value = cell_value[g-1];
      assign left_valid = cell_valid[g-1];
      assign left_gt    = cell_gt[g-1];
    end

    if (g == MAX_ITEMS - 1) begin : g_end
      assign right_value = cell_value[g];
      assign right_valid = 1'b0;
    end else begin : g_inner
      assign right_value = cell_value[g+1];
      assign right_valid = cell_valid[g+1];
    end

    isort_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .item_i       (in_i.item_value),
      .left_value_i (left_value),
      .left_valid_i (left_valid),
      .left_gt_i    (left_gt),
      .right_value_i(right_value),
      .right_valid_i(right_valid),
      .value_o      (cell_value[g]),
      .valid_o      (cell_valid[g]),
      .gt_o         (cell_gt[g])
    );
  end

  always_comb begin
    state_d   = state_q;
    occ_d     = occ_q;
    acc_d     = 1'b0;
    total_d   = total_q;
    dropped_d = dropped_q;

    if (acc_q) begin
      total_d = sum[SUM_W-1] ? isort_pkg::SHIFT_SAT : sum[isort_pkg::SHIFT_W-1:0];
    end

    unique case (state_q)
      isort_pkg::ST_IDLE: begin
        if (in_beat) begin
          if (has_room) begin
            occ_d = occ_q + OCC_W'(1);
            acc_d = 1'b1;
          end else begin
            dropped_d = 1'b1;
          end
          if (in_i.last_item) begin
            state_d = isort_pkg::ST_SETTLE;
          end
        end
      end
      isort_pkg::ST_SETTLE: begin
        state_d = isort_pkg::ST_DRAIN;
      end
      isort_pkg::ST_DRAIN: begin
        if (last_beat) begin
          occ_d     = '0;
          total_d   = '0;
          dropped_d = 1'b0;
          state_d   = isort_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = isort_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= isort_pkg::ST_IDLE;
      occ_q     <= '0;
      acc_q     <= 1'b0;
      total_q   <= '0;
      dropped_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      occ_q     <= occ_d;
      acc_q     <= acc_d;
      total_q   <= total_d;
      dropped_q <= dropped_d;
    end
  end

  // compare snapshot of each inserted beat, summed in the following cycle
  always_ff @(posedge clk_i) begin
    if (ctrl.insert) begin
      gt_q   <= cell_gt;
      snap_q <= occ_q;
    end
  end

endmodule

// ----- sim/insertion_sorter_with_shift_count_tb.sv -----
module insertion_sorter_with_shift_count_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned          ITEM_W      = isort_pkg::ITEM_W;
  localparam int unsigned          SHIFT_W     = isort_pkg::SHIFT_W;
  localparam logic [SHIFT_W-1:0]   SHIFT_SAT   = isort_pkg::SHIFT_SAT;
  localparam int unsigned CAPACITY    = isort_pkg::MAX_ITEMS_DEF;
  localparam int unsigned RANDOM_GOAL = 100;
  localparam int unsigned QUIET_TAIL  = 25;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned CYCLE_LIMIT = 100000;

  typedef struct {
    logic signed [ITEM_W-1:0] value;
    logic                     last;
  } item_beat_t;

  typedef struct {
    logic signed [ITEM_W-1:0]  value;
    logic                      last;
    logic        [SHIFT_W-1:0] shifts;
    logic                      ovf;
  } sorted_beat_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  isort_in_if  in_if ();
  isort_out_if out_if ();

  insertion_sorter_with_shift_count dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #1 clk_i = ~clk_i;

  item_beat_t   items_q[$];
  sorted_beat_t sorted_q[$];

  // shadow of the sorter
  logic signed [ITEM_W-1:0] held[$];
  int unsigned              shift_sum;
  bit                       dropped;

  int unsigned total_items;
  int unsigned items_taken;
  int unsigned cycle_cnt;
  int unsigned mismatches;
  bit          in_fire;
  bit          hold_arm;
  bit          hold_used;
  int unsigned hold_cnt;
  int unsigned send_idle;
  int unsigned recv_idle;

  function automatic bit quiet_phase();
    return items_taken + QUIET_TAIL >= total_items;
  endfunction

  task automatic add_item(input logic signed [ITEM_W-1:0] v, input logic lst);
    item_beat_t b;
    b.value = v;
    b.last  = lst;
    items_q.push_back(b);
  endtask

  task automatic absorb_item(input logic signed [ITEM_W-1:0] v, input logic lst);
    int unsigned  pos;
    int unsigned  moved;
    sorted_beat_t b;
    if (held.size() >= CAPACITY) begin
      dropped = 1'b1;
    end else begin
      pos = 0;
      // equal values go after the ones already held
      while (pos < held.size() && held[pos] <= v) pos++;
      moved = held.size() - pos;
      held.insert(pos, v);
      shift_sum = shift_sum + moved;
      if (shift_sum > SHIFT_SAT) shift_sum = SHIFT_SAT;
    end
    if (lst) begin
      foreach (held[k]) begin
        b.value  = held[k];
        b.last   = (k == held.size() - 1);
        b.shifts = shift_sum[SHIFT_W-1:0];
        b.ovf    = dropped;
        sorted_q.push_back(b);
      end
      held.delete();
      shift_sum = 0;
      dropped   = 1'b0;
    end
  endtask

  task automatic report(input string what, input logic [ITEM_W-1:0] got,
                        input logic [ITEM_W-1:0] want);
    mismatches++;
    $display("[%0t] %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  function automatic logic signed [ITEM_W-1:0] rand_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5, 6, 7:       return int'($urandom_range(0, 8)) - 4;
      8:             return $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default:       return $urandom_range(0, 1) ? 32'sh7fff_ffff - int'($urandom_range(0, 3))
                                                 : 32'sh8000_0000 + int'($urandom_range(0, 3));
    endcase
  endfunction

  // input side: acceptance, prediction, timeout counter, hold-off trigger
  always @(posedge clk_i) begin
    cycle_cnt++;
    in_fire = in_if.valid && in_if.ready;
    if (in_fire) begin
      absorb_item(in_if.item_value, in_if.last_item);
      items_taken++;
    end
    if (!hold_arm && out_if.valid && items_taken >= 40) hold_arm = 1'b1;
  end

  // output side checking
  always @(posedge clk_i) begin
    sorted_beat_t w;
    if (out_if.valid && out_if.ready) begin
      if (sorted_q.size() == 0) begin
        report("unexpected beat", out_if.sorted_value, '0);
      end else begin
        w = sorted_q.pop_front();
        if (out_if.sorted_value !== w.value)
          report("sorted_value", out_if.sorted_value, w.value);
        if (out_if.last_out !== w.last)
          report("last_out", ITEM_W'(out_if.last_out), ITEM_W'(w.last));
        if (out_if.shift_count !== w.shifts)
          report("shift_count", ITEM_W'(out_if.shift_count), ITEM_W'(w.shifts));
        if (out_if.overflow !== w.ovf)
          report("overflow", ITEM_W'(out_if.overflow), ITEM_W'(w.ovf));
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    item_beat_t b;
    if (rst_ni && !(in_if.valid && !in_fire)) begin
      if (send_idle > 0) begin
        in_if.valid <= 1'b0;
        send_idle--;
      end else if (items_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (!quiet_phase() && $urandom_range(0, 7) == 0) begin
        in_if.valid <= 1'b0;
        send_idle = $urandom_range(0, 9);
      end else begin
        b = items_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.item_value <= b.value;
        in_if.last_item  <= b.last;
      end
    end
  end

  // receiver, with one long hold-off while a full set waits to drain
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_arm && !hold_used) begin
        hold_used = 1'b1;
        hold_cnt  = HOLD_CYCLES;
      end
      if (hold_cnt > 0) begin
        out_if.ready <= 1'b0;
        hold_cnt--;
      end else if (recv_idle > 0) begin
        out_if.ready <= 1'b0;
        recv_idle--;
      end else if (!quiet_phase() && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        recv_idle = $urandom_range(0, 9);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    int unsigned n;
    int unsigned len;
    in_if.valid      = 1'b0;
    in_if.item_value = '0;
    in_if.last_item  = 1'b0;
    out_if.ready     = 1'b0;

    // lone minimum
    add_item(32'sh8000_0000, 1'b1);
    // extremes in awkward order
    add_item(32'sh7fff_ffff, 1'b0);
    add_item(32'sh8000_0000, 1'b0);
    add_item(32'sh0000_0000, 1'b0);
    add_item(-32'sd1,        1'b0);
    add_item(32'sh0000_0001, 1'b1);
    // ties keep arrival order
    add_item(32'sd5,  1'b0);
    add_item(32'sd5,  1'b0);
    add_item(-32'sd3, 1'b0);
    add_item(32'sd5,  1'b1);
    // strictly descending fill to capacity, then two dropped, last on a dropped one
    for (int i = 0; i < CAPACITY; i++) add_item(32'sd1000 - i, 1'b0);
    add_item(32'sd7, 1'b0);
    add_item(-32'sd7, 1'b1);

    n = 0;
    while (n < RANDOM_GOAL) begin
      len = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
      for (int i = 0; i < len; i++) add_item(rand_value(), i == len - 1);
      n += len;
    end
    total_items = items_q.size();

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (items_taken < total_items || sorted_q.size() != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
